[src/jfps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jfps_pkg
// Shared constants and types for the four-point Jacobi stencil sweep.
// ----------------------------------------------------------------------------
package jfps_pkg;

  localparam int MAX_GRID_DEF   = 4096;
  localparam int VALUE_BITS_DEF = 16;
  localparam int GRID_RESET     = 2048;
  localparam int GRID_MIN       = 3;
  localparam int CFG_W          = 13;
  localparam int CELL_W         = 16;
  localparam int IDX_W          = 12;
  localparam int FIFO_DEPTH     = 8;

  // One result transaction as held in the output queue
  typedef struct packed {
    logic              last;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  row;
    logic [CELL_W-1:0] value;
  } result_t;

endpackage : jfps_pkg
`default_nettype wire

[src/jacobi_four_point_stencil.sv]
`timescale 1ns / 1ps
`default_nettype none
// A result reaches out_* through the stage-one registers and the output queue.
// Throughput: one input transaction per cycle while the output queue has room;
// the line store is read and written once per cycle at one column. On the last row
// each input yields two results, so the output port (one per cycle) paces the input there.
// Reset: counters, output queue and stage flag clear, grid size returns to
// 2048; the line store is not cleared (raster order writes before it reads).
// ----------------------------------------------------------------------------
// jacobi_four_point_stencil
// Streaming Jacobi sweep: interior cells take the quarter of the sum of their
// four neighbours, edge cells pass through. Output runs one row behind input.
// ----------------------------------------------------------------------------
module jacobi_four_point_stencil
  import jfps_pkg::*;
#(
  parameter int MAX_GRID   = MAX_GRID_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration: grid_size
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_data,
  // input stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [15:0]       in_tdata,     // [15:0] cell_value
  // result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [39:0]            out_tdata,    // [15:0] new_value, [27:16] out_row,
                                               // [39:28] out_col
  output logic                   out_tlast     // frame_end
);

  localparam int CW      = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
  localparam int VB      = VALUE_BITS;
  localparam int RESET_N = (GRID_RESET > MAX_GRID) ? MAX_GRID : GRID_RESET;
  localparam int PW      = $clog2(FIFO_DEPTH);
  localparam int QW      = $clog2(FIFO_DEPTH + 1);

  // Line store: entry c holds {row r-2, row r-1} ahead of column c,
  // {row r-1, row r} once column c of row r has gone through.
  logic [2*VB-1:0] line_mem [MAX_GRID];
  logic [2*VB-1:0] rd_q;

  logic [CW-1:0] last_idx_r, last_idx_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [VB-1:0] left_r;

  // Stage one: registered operands of the accepted cell
  logic          s1_v_r, s1_v_nxt;
  logic [VB-1:0] s1_up_r, s1_centre_r, s1_left_r, s1_cell_r;
  logic [CW-1:0] s1_row_r, s1_col_r;
  logic          s1_emit_a_r, s1_emit_b_r, s1_bnd_r, s1_last_r;

  result_t       fifo_q [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QW-1:0] count_r, count_nxt;

  logic          in_fire, out_fire, cfg_fire;
  logic [VB-1:0] cell_v, cur_up, cur_centre, right_v;
  logic [CW-1:0] rd_addr;
  logic [VB+1:0] sum;
  logic [VB-1:0] avg;
  logic          push_a, push_b;
  logic [1:0]    push_n;
  logic [QW-1:0] free_n, need_n;
  result_t       res_a, res_b;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = out_tvalid & out_tready;

  assign cell_v     = VB'(in_tdata);
  assign cur_up     = rd_q[2*VB-1:VB];
  assign cur_centre = rd_q[VB-1:0];
  assign rd_addr    = (col_r == last_idx_r) ? '0 : col_r + 1'b1;

  // Grid size, clamped once on write
  always_comb begin
    last_idx_nxt = last_idx_r;
    if (cfg_fire) begin
      if (cfg_data < CFG_W'(GRID_MIN)) begin
        last_idx_nxt = CW'(GRID_MIN - 1);
      end else if (32'(cfg_data) > MAX_GRID) begin
        last_idx_nxt = CW'(MAX_GRID - 1);
      end else begin
        last_idx_nxt = CW'(cfg_data - 1'b1);
      end
    end
  end

  // Raster position; a configuration write restarts the frame
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_fire) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_fire) begin
      if (col_r == last_idx_r) begin
        col_nxt = '0;
        row_nxt = (row_r == last_idx_r) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_idx_r <= CW'(RESET_N - 1);
      row_r      <= '0;
      col_r      <= '0;
      s1_v_r     <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      count_r    <= '0;
    end else begin
      last_idx_r <= last_idx_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      s1_v_r     <= s1_v_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      count_r    <= count_nxt;
    end
  end

  assign s1_v_nxt = in_fire;

  // Write back this column, prefetch the next one
  always_ff @(posedge clk) begin
    if (in_fire) begin
      line_mem[col_r] <= {cur_centre, cell_v};
      rd_q            <= line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      left_r      <= cur_centre;
      s1_up_r     <= cur_up;
      s1_centre_r <= cur_centre;
      s1_left_r   <= left_r;
      s1_cell_r   <= cell_v;
      s1_row_r    <= row_r;
      s1_col_r    <= col_r;
      s1_emit_a_r <= (row_r != '0);
      s1_emit_b_r <= (row_r == last_idx_r);
      s1_bnd_r    <= (row_r == CW'(1)) || (col_r == '0) || (col_r == last_idx_r);
      s1_last_r   <= (col_r == last_idx_r);
    end
  end

  // Stage one: the prefetched entry now supplies the right-hand neighbour
  assign right_v = rd_q[VB-1:0];
  assign sum     = (VB+2)'(s1_up_r) + (VB+2)'(s1_cell_r)
                 + (VB+2)'(s1_left_r) + (VB+2)'(right_v);
  assign avg     = sum[VB+1:2];

  always_comb begin
    res_a.value = s1_bnd_r ? CELL_W'(s1_centre_r) : CELL_W'(avg);
    res_a.row   = IDX_W'(s1_row_r - 1'b1);
    res_a.col   = IDX_W'(s1_col_r);
    res_a.last  = 1'b0;
    res_b.value = CELL_W'(s1_cell_r);
    res_b.row   = IDX_W'(s1_row_r);
    res_b.col   = IDX_W'(s1_col_r);
    res_b.last  = s1_last_r;
  end

  assign push_a = s1_v_r & s1_emit_a_r;
  assign push_b = s1_v_r & s1_emit_b_r;
  assign push_n = {1'b0, push_a} + {1'b0, push_b};

  // Hold input unless the queue can take the pending results plus two more
  assign free_n    = QW'(FIFO_DEPTH) - count_r;
  assign need_n    = QW'(push_n) + QW'(2);
  assign in_tready = (free_n >= need_n);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push_n);
    rd_ptr_nxt = rd_ptr_r + PW'(out_fire);
    count_nxt  = count_r + QW'(push_n) - QW'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      fifo_q[wr_ptr_r] <= res_a;
    end
    if (push_b) begin
      fifo_q[wr_ptr_r + PW'(push_a)] <= res_b;
    end
  end

  assign out_tvalid = (count_r != '0);
  assign out_tdata  = {fifo_q[rd_ptr_r].col, fifo_q[rd_ptr_r].row, fifo_q[rd_ptr_r].value};
  assign out_tlast  = fifo_q[rd_ptr_r].last;

endmodule : jacobi_four_point_stencil
`default_nettype wire
